// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/tgp_pkg.sv -----
// Package for the thread grid partition block: sequencer states and constants.
package tgp_pkg;

  // Counts below this go wholly to one side.
  localparam int SMALL_COUNT = 4;

  // Fixed trial divisor candidates before the linear run.
  localparam int CAND_FIRST = 2;
  localparam int CAND_2ND   = 3;
  localparam int CAND_3RD   = 5;
  localparam int CAND_4TH   = 7;
  localparam int CAND_RUN   = 11;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DIV_REM,
    ST_ASSIGN,
    ST_DIV_WORK,
    ST_CMP,
    ST_BAL1,
    ST_BAL2,
    ST_BAL3
  } state_t;

endpackage

// ----- design/tgp_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module tgp_div #(
  parameter int DIVIDEND_BITS = 32,
  parameter int DIVISOR_BITS  = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     busy,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient,
  output logic [DIVISOR_BITS-1:0]  remainder
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [CNT_BITS-1:0]     count;
  logic [DIVISOR_BITS:0]   rmd_shift;
  logic                    fits;
  logic [DIVISOR_BITS:0]   rmd_sub;

  // One step: shift in the next dividend bit and try the subtract.
  assign rmd_shift = {remainder, quotient[DIVIDEND_BITS-1]};
  assign fits      = rmd_shift >= {1'b0, divisor};
  assign rmd_sub   = rmd_shift - {1'b0, divisor};
  assign busy      = count != '0;

  // Step counter and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        count <= CNT_BITS'(DIVIDEND_BITS);
      end else if (busy) begin
        count <= count - 1'b1;
        done  <= count == CNT_BITS'(1);
      end
    end
  end

  // Quotient and partial remainder.
  always_ff @(posedge clk) begin
    if (go) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[DIVIDEND_BITS-2:0], fits};
      remainder <= fits ? rmd_sub[DIVISOR_BITS-1:0] : rmd_shift[DIVISOR_BITS-1:0];
    end
  end

endmodule

// ----- design/thread_grid_partition_2x2.sv -----
// Top level: splits a thread count into two factors weighted by work sizes.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-------------------------------------------
//  input    | start, busy            | thread_count, work_first, work_second
//  result   | done (one-cycle strobe)| threads_first, threads_second
//
// Counts below four finish with done in the cycle after start. Larger counts
// run trial division by each candidate up to the square root of the count,
// divide the busier side's work by each factor found, and then balance; all
// divisions use the shared bit-serial divider.
// Reset clears the sequencer and the strobe. Results cannot be stalled.
`include "assert_macros.svh"

module thread_grid_partition_2x2 #(
  parameter int COUNT_BITS = 12,
  parameter int WORK_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COUNT_BITS-1:0] thread_count,
  input  logic [WORK_BITS-1:0]  work_first,
  input  logic [WORK_BITS-1:0]  work_second,
  output logic                  done,
  output logic [COUNT_BITS-1:0] threads_first,
  output logic [COUNT_BITS-1:0] threads_second
);

  localparam int DW = (WORK_BITS > COUNT_BITS) ? WORK_BITS : COUNT_BITS;

  tgp_pkg::state_t state, state_next;

  logic [COUNT_BITS-1:0]   n, rem, f, fac, t1, t2;
  logic [WORK_BITS-1:0]    w1, w2, gap, a;
  logic [WORK_BITS:0]      b, alt;
  logic                    side_first, w1_gt, w1_lt, a_ge_b;
  logic [2*COUNT_BITS-1:0] f_sq;
  logic                    in_range;

  logic                    div_go, div_busy, div_done;
  logic [DW-1:0]           div_dividend, div_quo;
  logic [COUNT_BITS-1:0]   div_divisor, div_rmd;

  logic [WORK_BITS-1:0]    hi, lo;
  logic [2*COUNT_BITS-1:0] out_prod;

  // Next trial divisor: the fixed primes, then every integer.
  function automatic logic [COUNT_BITS-1:0] next_cand(input logic [COUNT_BITS-1:0] cur);
    logic [COUNT_BITS-1:0] res;
    res = cur + 1'b1;
    if (cur == COUNT_BITS'(tgp_pkg::CAND_FIRST)) res = COUNT_BITS'(tgp_pkg::CAND_2ND);
    else if (cur == COUNT_BITS'(tgp_pkg::CAND_2ND)) res = COUNT_BITS'(tgp_pkg::CAND_3RD);
    else if (cur == COUNT_BITS'(tgp_pkg::CAND_3RD)) res = COUNT_BITS'(tgp_pkg::CAND_4TH);
    else if (cur == COUNT_BITS'(tgp_pkg::CAND_4TH)) res = COUNT_BITS'(tgp_pkg::CAND_RUN);
    return res;
  endfunction

  // Candidate stays within the square root of the original count.
  assign f_sq     = {{COUNT_BITS{1'b0}}, f} * {{COUNT_BITS{1'b0}}, f};
  assign in_range = f_sq <= {{COUNT_BITS{1'b0}}, n};
  assign busy     = state != tgp_pkg::ST_IDLE;

  // Busier and lighter side for the balancing step.
  assign hi = w1_gt ? w1 : w2;
  assign lo = w1_gt ? w2 : w1;

  // Divider feed: trial division of the remainder, or work by a factor.
  always_comb begin
    div_go       = 1'b0;
    div_dividend = DW'(rem);
    div_divisor  = f;
    case (state)
      tgp_pkg::ST_SEARCH: begin
        div_go = in_range;
      end
      tgp_pkg::ST_ASSIGN: begin
        div_go       = 1'b1;
        div_dividend = (w1 > w2) ? DW'(w1) : DW'(w2);
        div_divisor  = fac;
      end
      default: begin
        div_go = 1'b0;
      end
    endcase
  end

  tgp_div #(
    .DIVIDEND_BITS (DW),
    .DIVISOR_BITS  (COUNT_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rmd)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tgp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tgp_pkg::ST_IDLE: begin
        if (start && thread_count >= COUNT_BITS'(tgp_pkg::SMALL_COUNT)) begin
          state_next = tgp_pkg::ST_SEARCH;
        end
      end
      tgp_pkg::ST_SEARCH: begin
        if (in_range) state_next = tgp_pkg::ST_DIV_REM;
        else if (rem <= COUNT_BITS'(1)) state_next = tgp_pkg::ST_CMP;
        else state_next = tgp_pkg::ST_ASSIGN;
      end
      tgp_pkg::ST_DIV_REM: begin
        if (div_done) begin
          state_next = (div_rmd == '0) ? tgp_pkg::ST_ASSIGN : tgp_pkg::ST_SEARCH;
        end
      end
      tgp_pkg::ST_ASSIGN:   state_next = tgp_pkg::ST_DIV_WORK;
      tgp_pkg::ST_DIV_WORK: begin
        if (div_done) state_next = tgp_pkg::ST_SEARCH;
      end
      tgp_pkg::ST_CMP:  state_next = tgp_pkg::ST_BAL1;
      tgp_pkg::ST_BAL1: state_next = tgp_pkg::ST_BAL2;
      tgp_pkg::ST_BAL2: state_next = tgp_pkg::ST_BAL3;
      tgp_pkg::ST_BAL3: state_next = tgp_pkg::ST_IDLE;
      default:          state_next = tgp_pkg::ST_IDLE;
    endcase
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == tgp_pkg::ST_BAL3) ||
              (state == tgp_pkg::ST_IDLE && start &&
               thread_count < COUNT_BITS'(tgp_pkg::SMALL_COUNT));
    end
  end

  // Datapath registers, updated per sequencer step.
  always_ff @(posedge clk) begin
    case (state)
      tgp_pkg::ST_IDLE: begin
        if (start) begin
          n   <= thread_count;
          rem <= thread_count;
          w1  <= work_first;
          w2  <= work_second;
          f   <= COUNT_BITS'(tgp_pkg::CAND_FIRST);
          t1  <= COUNT_BITS'(1);
          t2  <= COUNT_BITS'(1);
          // Small counts go wholly to the busier side, ties to the first.
          threads_first  <= (work_first >= work_second) ? thread_count : COUNT_BITS'(1);
          threads_second <= (work_first < work_second) ? thread_count : COUNT_BITS'(1);
        end
      end
      tgp_pkg::ST_SEARCH: begin
        // Candidates exhausted: the remainder is the last factor.
        if (!in_range) begin
          fac <= rem;
          rem <= COUNT_BITS'(1);
        end
      end
      tgp_pkg::ST_DIV_REM: begin
        if (div_done) begin
          if (div_rmd == '0) begin
            fac <= f;
            rem <= div_quo[COUNT_BITS-1:0];
          end else begin
            f <= next_cand(f);
          end
        end
      end
      tgp_pkg::ST_ASSIGN: begin
        // The factor goes to the first side only if it has strictly more work; ties go to the second.
        side_first <= w1 > w2;
        if (w1 > w2) t1 <= t1 * fac;
        else t2 <= t2 * fac;
      end
      tgp_pkg::ST_DIV_WORK: begin
        if (div_done) begin
          if (side_first) w1 <= div_quo[WORK_BITS-1:0];
          else w2 <= div_quo[WORK_BITS-1:0];
        end
      end
      tgp_pkg::ST_CMP: begin
        w1_gt <= w1 > w2;
        w1_lt <= w1 < w2;
      end
      tgp_pkg::ST_BAL1: begin
        gap    <= hi - lo;
        a      <= hi >> 1;
        b      <= {lo, 1'b0};
        a_ge_b <= {1'b0, hi >> 1} >= {lo, 1'b0};
      end
      tgp_pkg::ST_BAL2: begin
        alt <= a_ge_b ? ({1'b0, a} - b) : (b - {1'b0, a});
      end
      tgp_pkg::ST_BAL3: begin
        // Move one factor of two toward the busier side if the gap shrinks.
        threads_first  <= t1;
        threads_second <= t2;
        if (w1_gt && !t2[0] && alt < {1'b0, gap}) begin
          threads_first  <= {t1[COUNT_BITS-2:0], 1'b0};
          threads_second <= t2 >> 1;
        end else if (w1_lt && !t1[0] && alt < {1'b0, gap}) begin
          threads_first  <= t1 >> 1;
          threads_second <= {t2[COUNT_BITS-2:0], 1'b0};
        end
      end
      default: begin
        fac <= fac;
      end
    endcase
  end

  // Product of the two factors, for checking.
  assign out_prod = {{COUNT_BITS{1'b0}}, threads_first} *
                    {{COUNT_BITS{1'b0}}, threads_second};

  `ASSERT_IMPLY(a_prod_matches, clk, rst, done, out_prod == (2*COUNT_BITS)'(n), "factors do not multiply to the count")
  `ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, busy || done, "accepted item neither busy nor done")
  `ASSERT_IMPLY(a_div_active, clk, rst, (state == tgp_pkg::ST_DIV_REM || state == tgp_pkg::ST_DIV_WORK) && !div_done, div_busy, "sequencer waits on an idle divider")

endmodule
